// ----- rtl/core/compacted_message_slot_table_top_assert.svh -----
// Assertion macros for the compacted message slot table.
// Included by the top level; no other dependencies.
`ifndef COMPACTED_MESSAGE_SLOT_TABLE_TOP_ASSERT_SVH
`define COMPACTED_MESSAGE_SLOT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMST_ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cmst: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMST_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cmst: assertion failed");

`endif

// ----- rtl/core/cmst_pkg.sv -----
// Shared types and constants of the compacted message slot table.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cmst_pkg;

	// Fixed widths of the word fields
	localparam int unsigned OP_W        = 3;
	localparam int unsigned SLOT_W      = 5;
	localparam int unsigned HANDLE_W    = 32;
	localparam int unsigned CODE_W      = 2;
	localparam int unsigned COUNT_OUT_W = 6;
	localparam int unsigned STATE_W     = 2;
	localparam int unsigned DELAY_W     = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK_READ = 3'd2;
	localparam logic [OP_W-1:0] OP_READ      = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

	// Result codes
	localparam logic [CODE_W-1:0] RC_OK        = 2'd0;
	localparam logic [CODE_W-1:0] RC_DUP       = 2'd1;
	localparam logic [CODE_W-1:0] RC_FULL      = 2'd2;
	localparam logic [CODE_W-1:0] RC_BAD_INDEX = 2'd3;

	// Table state codes
	localparam logic [STATE_W-1:0] TS_OLD  = 2'd0;
	localparam logic [STATE_W-1:0] TS_NEW  = 2'd1;
	localparam logic [STATE_W-1:0] TS_FULL = 2'd2;

	// Write-back timer
	localparam logic [DELAY_W-1:0] FLUSH_DELAY_RST = DELAY_W'(2 * 1000);
	localparam logic [DELAY_W-1:0] TICKS_MAX       = {DELAY_W{1'b1}};

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic shift;
		logic finish;
	} cmst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_shift;
		logic shift_more;
		logic out_free;
	} cmst_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cmst_ctrl.sv -----
// Sequencer of the compacted message slot table: load, execute, shift, finish.
// Depends on cmst_pkg for the command and status types.
`default_nettype none

module cmst_ctrl
	import cmst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  cmst_status_t st,
	output cmst_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SHIFT  = 4'b0100,
		ST_FINISH = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = st.need_shift ? ST_SHIFT : ST_FINISH;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (!st.shift_more) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register can take the word
				cmd.finish = st.out_free;
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cmst_dp.sv -----
// Datapath of the compacted message slot table: entry memory, unread marks,
// counters, write-back timer and output register. Depends on cmst_pkg.
`default_nettype none

module cmst_dp
	import cmst_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmst_cmd_t              cmd,
	output cmst_status_t           st,
	input  logic [OP_W-1:0]        op,
	input  logic [SLOT_W-1:0]      slot_index,
	input  logic [HANDLE_W-1:0]    entry_data,
	input  logic                   cfg_we,
	input  logic [DELAY_W-1:0]     cfg_data,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [CODE_W-1:0]      result_code,
	output logic [HANDLE_W-1:0]    read_data,
	output logic                   read_unread,
	output logic [COUNT_OUT_W-1:0] total_count,
	output logic [COUNT_OUT_W-1:0] unread_count,
	output logic [STATE_W-1:0]     table_state,
	output logic                   flush_request
);

	localparam int unsigned IW   = $clog2(TABLE_DEPTH);
	localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CMPW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int unsigned XW   = (ENTRY_WIDTH > HANDLE_W) ? ENTRY_WIDTH : HANDLE_W;
	localparam int unsigned OCW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

	// Item registers
	logic [OP_W-1:0]        op_q;
	logic [SLOT_W-1:0]      idx_q;
	logic [ENTRY_WIDTH-1:0] data_q;

	// Table state
	logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_q;
	logic [TABLE_DEPTH-1:0] mark_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          unread_q;
	logic [ENTRY_WIDTH-1:0] last_q;
	logic                   dirty_q;
	logic [DELAY_W-1:0]     elapsed_q;
	logic [DELAY_W-1:0]     delay_q;
	logic [IW-1:0]          ptr_q;

	// Per-item results
	logic [CODE_W-1:0] code_q;
	logic              flush_q;
	logic              rhit_q;
	logic              runread_q;

	// Output register
	logic                   out_valid_q;
	logic [CODE_W-1:0]      result_code_q;
	logic [HANDLE_W-1:0]    read_data_q;
	logic                   read_unread_q;
	logic [COUNT_OUT_W-1:0] total_count_q;
	logic [COUNT_OUT_W-1:0] unread_count_q;
	logic [STATE_W-1:0]     table_state_q;
	logic                   flush_request_q;

	logic [XW-1:0]          in_data_x;
	logic [XW-1:0]          rd_x;
	logic [CMPW-1:0]        idx_x;
	logic [CMPW-1:0]        cnt_x;
	logic [IW-1:0]          idx_w;
	logic [IW-1:0]          count_w;
	logic [OCW-1:0]         count_ox;
	logic [OCW-1:0]         unread_ox;
	logic                   idx_ok;
	logic                   full;
	logic                   dup;
	logic                   add_ok;
	logic                   del_ok;
	logic                   mark_ok;
	logic                   read_ok;
	logic                   mark_at_idx;
	logic [TABLE_DEPTH:0]   mark_ext;
	logic [TABLE_DEPTH-1:0] mark_shifted;
	logic [DELAY_W-1:0]     tick_next;
	logic                   tick_hit;
	logic [CODE_W-1:0]      code_d;
	logic                   we;
	logic [IW-1:0]          wa;
	logic [ENTRY_WIDTH-1:0] wd;
	logic                   re;
	logic [IW-1:0]          ra;

	assign in_data_x = XW'(entry_data);
	assign rd_x      = XW'(rd_q);
	assign idx_x     = CMPW'(idx_q);
	assign cnt_x     = CMPW'(count_q);
	assign idx_w     = idx_x[IW-1:0];
	assign count_w   = count_q[IW-1:0];
	assign count_ox  = OCW'(count_q);
	assign unread_ox = OCW'(unread_q);

	assign idx_ok  = idx_x < cnt_x;
	assign full    = count_q == CW'(TABLE_DEPTH);
	assign dup     = data_q == last_q;
	assign add_ok  = (op_q == OP_ADD) && !dup && !full;
	assign del_ok  = (op_q == OP_DELETE) && idx_ok;
	assign mark_ok = (op_q == OP_MARK_READ) && idx_ok;
	assign read_ok = (op_q == OP_READ) && idx_ok;

	assign mark_at_idx = mark_q[idx_w];
	assign mark_ext    = {1'b0, mark_q};

	// Close the gap in the unread marks at the deleted position
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			mark_shifted[i] = (i < int'(idx_w)) ? mark_ext[i] : mark_ext[i+1];
		end
	end

	assign tick_next = (elapsed_q == TICKS_MAX) ? elapsed_q : elapsed_q + DELAY_W'(1);
	assign tick_hit  = tick_next >= delay_q;

	always_comb begin
		code_d = RC_OK;
		case (op_q)
			OP_ADD: begin
				if (dup) begin
					code_d = RC_DUP;
				end else if (full) begin
					code_d = RC_FULL;
				end
			end
			OP_DELETE, OP_MARK_READ, OP_READ: begin
				if (!idx_ok) begin
					code_d = RC_BAD_INDEX;
				end
			end
			default: begin
				code_d = RC_OK;
			end
		endcase
	end

	// Status toward the controller
	assign st.need_shift = del_ok &&
		((CMPW + 1)'(idx_x) + (CMPW + 1)'(1) < (CMPW + 1)'(cnt_x));
	assign st.shift_more = ((CW + 1)'(ptr_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
	assign st.out_free   = !out_valid_q || !out_stall;

	// Memory port steering: append on add, move one entry down per shift cycle
	assign we = (cmd.exec && add_ok) || cmd.shift;
	assign wa = cmd.shift ? ptr_q : count_w;
	assign wd = cmd.shift ? rd_q : data_q;
	assign re = (cmd.exec && (del_ok || read_ok)) || cmd.shift;

	always_comb begin
		if (cmd.shift) begin
			ra = ptr_q + IW'(2);
		end else if (op_q == OP_DELETE) begin
			ra = idx_w + IW'(1);
		end else begin
			ra = idx_w;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			idx_q  <= slot_index;
			data_q <= in_data_x[ENTRY_WIDTH-1:0];
		end
		if (cmd.exec) begin
			code_q    <= code_d;
			flush_q   <= (op_q == OP_TICK) && dirty_q && tick_hit;
			rhit_q    <= read_ok;
			runread_q <= mark_at_idx;
			ptr_q     <= idx_w;
		end else if (cmd.shift) begin
			ptr_q <= ptr_q + IW'(1);
		end
		if (cmd.finish) begin
			result_code_q   <= code_q;
			read_data_q     <= rhit_q ? rd_x[HANDLE_W-1:0] : '0;
			read_unread_q   <= rhit_q & runread_q;
			total_count_q   <= count_ox[COUNT_OUT_W-1:0];
			unread_count_q  <= unread_ox[COUNT_OUT_W-1:0];
			flush_request_q <= flush_q;
			if (full) begin
				table_state_q <= TS_FULL;
			end else if (unread_q != '0) begin
				table_state_q <= TS_NEW;
			end else begin
				table_state_q <= TS_OLD;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q      <= '0;
			count_q     <= '0;
			unread_q    <= '0;
			last_q      <= '0;
			dirty_q     <= 1'b0;
			elapsed_q   <= '0;
			delay_q     <= FLUSH_DELAY_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_data;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (op_q)
					OP_ADD: begin
						if (add_ok) begin
							mark_q[count_w] <= 1'b1;
							count_q         <= count_q + CW'(1);
							unread_q        <= unread_q + CW'(1);
							last_q          <= data_q;
							dirty_q         <= 1'b1;
							elapsed_q       <= '0;
						end
					end
					OP_DELETE: begin
						if (del_ok) begin
							mark_q    <= mark_shifted;
							count_q   <= count_q - CW'(1);
							unread_q  <= unread_q - CW'(mark_at_idx);
							dirty_q   <= 1'b1;
							elapsed_q <= '0;
						end
					end
					OP_MARK_READ: begin
						if (mark_ok) begin
							mark_q[idx_w] <= 1'b0;
							unread_q      <= unread_q - CW'(mark_at_idx);
							dirty_q       <= 1'b1;
							elapsed_q     <= '0;
						end
					end
					OP_TICK: begin
						if (dirty_q) begin
							elapsed_q <= tick_next;
							if (tick_hit) begin
								dirty_q <= 1'b0;
							end
						end
					end
					default: begin
						dirty_q <= dirty_q;
					end
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_code   = result_code_q;
	assign read_data     = read_data_q;
	assign read_unread   = read_unread_q;
	assign total_count   = total_count_q;
	assign unread_count  = unread_count_q;
	assign table_state   = table_state_q;
	assign flush_request = flush_request_q;

endmodule

`default_nettype wire

// ----- rtl/core/compacted_message_slot_table_top.sv -----
// Top level of the compacted message slot table: sequencer plus datapath.
// Depends on cmst_pkg, cmst_ctrl, cmst_dp and the assertion macro header.
//
//   channel  direction  handshake              word
//   -------  ---------  ---------------------  ---------------------------------
//   in       sink       in_valid / in_stall    op, slot_index, entry_data
//   out      source     out_valid / out_stall  result_code, read_data,
//                                              read_unread, total_count,
//                                              unread_count, table_state,
//                                              flush_request
//   cfg      sink       cfg_valid / cfg_ready  flush_delay
//
// One item at a time. Every item passes through the load, execute and finish steps;
// a delete with entries above the deleted one (up to TABLE_DEPTH - 1) also passes
// through the shift step, since the single write port of the entry memory moves
// one entry down per cycle.
// Reset clears counts, unread marks, last handle and timer; entry memory is not
// cleared. A stalled output word holds the block in its finish step.
`default_nettype none

module compacted_message_slot_table_top
	import cmst_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OP_W-1:0]        op,
	input  logic [SLOT_W-1:0]      slot_index,
	input  logic [HANDLE_W-1:0]    entry_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CODE_W-1:0]      result_code,
	output logic [HANDLE_W-1:0]    read_data,
	output logic                   read_unread,
	output logic [COUNT_OUT_W-1:0] total_count,
	output logic [COUNT_OUT_W-1:0] unread_count,
	output logic [STATE_W-1:0]     table_state,
	output logic                   flush_request,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [DELAY_W-1:0]     flush_delay
);

	cmst_cmd_t    cmd;
	cmst_status_t st;

	// Register writes must arrive only while idle; the block does not enforce this and takes them at once
	assign cfg_ready = 1'b1;

	cmst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	cmst_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.op            (op),
		.slot_index    (slot_index),
		.entry_data    (entry_data),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (flush_delay),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_code   (result_code),
		.read_data     (read_data),
		.read_unread   (read_unread),
		.total_count   (total_count),
		.unread_count  (unread_count),
		.table_state   (table_state),
		.flush_request (flush_request)
	);

`include "compacted_message_slot_table_top_assert.svh"

	// An accepted word closes the input until its result is out
	`CMST_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall)
	// The finish step always leaves a word in the output register
	`CMST_ASSERT_NEXT(a_finish_shows, clk, arst_n, cmd.finish, out_valid)
	// A flush request only ever comes from a tick, which never fails
	`CMST_ASSERT_IMPL(a_flush_ok, clk, arst_n, out_valid && flush_request, result_code == RC_OK)

endmodule

`default_nettype wire
